// File: hdl/ds18_pkg.sv
// shared types, constants and functions for the ds18x20 scratchpad decoder
// no dependencies; imported by ds18_decode and ds18x20_scratchpad_decoder

package ds18_pkg;

  localparam int SCRATCHPAD_BYTES = 9;
  localparam int POS_W            = $clog2(SCRATCHPAD_BYTES);

  localparam logic [POS_W-1:0] POS_TEMP_LSB  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TEMP_MSB  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CONFIG    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_COUNT_REM = POS_W'(6);
  localparam logic [POS_W-1:0] POS_COUNT_PER = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CRC       = POS_W'(SCRATCHPAD_BYTES - 1);

  localparam logic [7:0] CRC_POLY_REFLECTED = 8'h8C;

  localparam logic [7:0] FAMILY_DS18S20 = 8'h10;
  localparam logic [7:0] FAMILY_DS18B20 = 8'h28;
  localparam logic [7:0] FAMILY_DS1822  = 8'h22;

  localparam logic [7:0] COUNT_PER_C_NOMINAL = 8'h10;
  localparam logic [15:0] FRAC_MASK          = 16'hFFF0;
  localparam logic [15:0] HALF_LSB_OFFSET    = 16'd12;

  localparam logic [7:0] RES_MASK   = 8'h60;
  localparam logic [7:0] RES_9_BIT  = 8'h00;
  localparam logic [7:0] RES_10_BIT = 8'h20;
  localparam logic [7:0] RES_11_BIT = 8'h40;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_CRC_ERROR      = 2'd1,
    ST_UNKNOWN_FAMILY = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] scratch_byte;
    logic [7:0] family_code;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [1:0]         status;
  } out_item_t;

  // scratchpad bytes kept for the decode
  typedef struct packed {
    logic [7:0] temp_lsb;
    logic [7:0] temp_msb;
    logic [7:0] config_reg;
    logic [7:0] count_remain;
    logic [7:0] count_per_c;
  } scratch_hold_t;

  // dallas crc-8, one byte, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFLECTED;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/ds18_decode.sv
// temperature decode of a held scratchpad, combinational
// depends on ds18_pkg

module ds18_decode import ds18_pkg::*; (
  input  scratch_hold_t hold,
  input  logic [7:0]    family_code,
  input  logic          crc_match,
  output out_item_t     result
);

  logic [15:0] raw;
  logic [15:0] shifted;
  logic [15:0] temp;
  status_t     status;

  assign raw     = {hold.temp_msb, hold.temp_lsb};
  assign shifted = raw << 3;

  always_comb begin
    temp   = 16'd0;
    status = ST_OK;
    if (!crc_match) begin
      status = ST_CRC_ERROR;
    end else if (family_code == FAMILY_DS18S20) begin
      // count-remain refines it if count-per-c = 16; wraps mod 2^16
      if (hold.count_per_c == COUNT_PER_C_NOMINAL) begin
        temp = (shifted & FRAC_MASK) + HALF_LSB_OFFSET - {8'd0, hold.count_remain};
      end else begin
        temp = shifted;
      end
    end else if (family_code == FAMILY_DS18B20 || family_code == FAMILY_DS1822) begin
      unique case (hold.config_reg & RES_MASK)
        RES_9_BIT:  temp = raw & 16'hFFF8;
        RES_10_BIT: temp = raw & 16'hFFFC;
        RES_11_BIT: temp = raw & 16'hFFFE;
        default:    temp = raw;
      endcase
    end else begin
      status = ST_UNKNOWN_FAMILY;
    end
  end

  assign result.temperature = temp;
  assign result.status      = status;

endmodule

// File: hdl/ds18x20_scratchpad_decoder.sv
// top level of the ds18x20 scratchpad decoder: byte counter, crc and result register
// depends on ds18_pkg and ds18_decode

// Usage
// in_*  : one scratchpad byte per transaction, bytes 0 to 8 in order, with
//         the sensor family code; frame_start marks byte 0 and restarts the
//         byte count and the crc.
// out_* : one transaction per scratchpad, on byte 8: temperature in 1/16 C
//         and a status (ok, crc mismatch, unknown family).
// Throughput: one byte per cycle while in_stall is low. Latency: the result is registered and
//         appears in the cycle after byte 8 is taken.
// The crc update is one byte per cycle in the input path when not stalled; the decode sits
//         between the held bytes and the output register.
// Reset (rst_n low, synchronous) clears the count, the crc and out_valid.
// Stall: while a result waits under out_stall, bytes 0 to 7 are still taken;
//         a byte that arrives while the count stands at byte 8 is held off
//         with in_stall, with or without frame_start.

module ds18x20_scratchpad_decoder import ds18_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  scratch_hold_t    hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [POS_W-1:0] pos_cur;
  logic [7:0]       crc_cur;
  logic             in_take;
  out_item_t        dec_result;

  assign in_stall = out_valid_r && out_stall && (pos_r == POS_CRC);
  assign in_take  = in_valid && !in_stall;

  assign pos_cur = in_data.frame_start ? POS_TEMP_LSB : pos_r;
  assign crc_cur = in_data.frame_start ? 8'd0 : crc_r;

  ds18_decode u_decode (
    .hold        (hold_r),
    .family_code (in_data.family_code),
    .crc_match   (crc_cur == in_data.scratch_byte),
    .result      (dec_result)
  );

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    hold_nxt      = hold_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_take) begin
      if (pos_cur == POS_CRC) begin
        out_data_nxt  = dec_result;
        out_valid_nxt = 1'b1;
        pos_nxt       = POS_TEMP_LSB;
        crc_nxt       = 8'd0;
      end else begin
        unique case (pos_cur)
          POS_TEMP_LSB:  hold_nxt.temp_lsb     = in_data.scratch_byte;
          POS_TEMP_MSB:  hold_nxt.temp_msb     = in_data.scratch_byte;
          POS_CONFIG:    hold_nxt.config_reg   = in_data.scratch_byte;
          POS_COUNT_REM: hold_nxt.count_remain = in_data.scratch_byte;
          POS_COUNT_PER: hold_nxt.count_per_c  = in_data.scratch_byte;
          default: ;
        endcase
        crc_nxt = crc8_update(crc_cur, in_data.scratch_byte);
        pos_nxt = pos_cur + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_TEMP_LSB;
      crc_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for ds18x20_scratchpad_decoder: directed and random scratchpads,
// each reading checked against a predictor kept in the bench; depends on ds18_pkg and the rtl

module testbench import ds18_pkg::*;;

  localparam int FRAME_LEN   = SCRATCHPAD_BYTES;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_OFF    = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  typedef struct {
    logic [15:0] temperature;
    status_t     status;
  } reading_t;

  reading_t pending_readings[$];

  // predictor copy of the decoder state
  logic [7:0] pred_crc;
  logic [3:0] pred_pos;
  logic [7:0] held_lsb;
  logic [7:0] held_msb;
  logic [7:0] held_cfg;
  logic [7:0] held_remain;
  logic [7:0] held_per;

  int idle_pct;
  int stall_pct;
  int hold_off_req;
  int bytes_sent;
  int readings_checked;
  int held_off_cycles;
  int error_count;
  int status_seen [3];

  ds18x20_scratchpad_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bitwise dallas crc, lsb first
  function automatic logic [7:0] dallas_crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic predict_reading(input in_item_t item);
    logic [15:0] raw;
    reading_t    r;
    if (item.frame_start || pred_pos > 4'(FRAME_LEN - 1)) begin
      pred_pos = '0;
      pred_crc = '0;
    end
    if (pred_pos < 4'(FRAME_LEN - 1)) begin
      case (pred_pos)
        POS_TEMP_LSB:  held_lsb    = item.scratch_byte;
        POS_TEMP_MSB:  held_msb    = item.scratch_byte;
        POS_CONFIG:    held_cfg    = item.scratch_byte;
        POS_COUNT_REM: held_remain = item.scratch_byte;
        POS_COUNT_PER: held_per    = item.scratch_byte;
        default: ;
      endcase
      pred_crc = dallas_crc_byte(pred_crc, item.scratch_byte);
      pred_pos++;
    end else begin
      raw           = {held_msb, held_lsb};
      r.temperature = '0;
      if (pred_crc != item.scratch_byte) begin
        r.status = ST_CRC_ERROR;
      end else if (item.family_code == FAMILY_DS18S20) begin
        raw = raw << 3;
        if (held_per == COUNT_PER_C_NOMINAL) begin
          raw = (raw & FRAC_MASK) + HALF_LSB_OFFSET - {8'h00, held_remain};
        end
        r.temperature = raw;
        r.status      = ST_OK;
      end else if (item.family_code == FAMILY_DS18B20 || item.family_code == FAMILY_DS1822) begin
        // undefined low bits depend on the resolution setting
        case (held_cfg & RES_MASK)
          RES_9_BIT:  raw[2:0] = '0;
          RES_10_BIT: raw[1:0] = '0;
          RES_11_BIT: raw[0]   = 1'b0;
          default: ;
        endcase
        r.temperature = raw;
        r.status      = ST_OK;
      end else begin
        r.status = ST_UNKNOWN_FAMILY;
      end
      pending_readings.push_back(r);
      pred_pos = '0;
      pred_crc = '0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input logic [7:0] fam, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{scratch_byte: b, family_code: fam, frame_start: start};
    @(posedge clk);
    while (in_stall) begin
      held_off_cycles++;
      @(posedge clk);
    end
    predict_reading(in_data);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] lsb, input logic [7:0] msb, input logic [7:0] cfg,
                            input logic [7:0] remain, input logic [7:0] per,
                            input logic [7:0] fam, input logic start, input logic [7:0] crc_flip);
    logic [7:0] bytes [FRAME_LEN];
    logic [7:0] crc;
    foreach (bytes[i]) bytes[i] = 8'($urandom);
    bytes[POS_TEMP_LSB]  = lsb;
    bytes[POS_TEMP_MSB]  = msb;
    bytes[POS_CONFIG]    = cfg;
    bytes[POS_COUNT_REM] = remain;
    bytes[POS_COUNT_PER] = per;
    crc = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) crc = dallas_crc_byte(crc, bytes[i]);
    bytes[POS_CRC] = crc ^ crc_flip;
    // family code only matters on the crc byte, so the rest carry noise
    for (int i = 0; i < FRAME_LEN; i++) begin
      send_byte(bytes[i], (i == FRAME_LEN - 1) ? fam : 8'($urandom), (i == 0) ? start : 1'b0);
    end
  endtask

  task automatic send_random_scratchpad();
    int         kind;
    int         n;
    logic [7:0] fam;
    logic [7:0] lsb;
    logic [7:0] msb;
    logic [7:0] per;
    logic [7:0] flip;
    kind = $urandom_range(99);
    case ($urandom_range(3))
      0:       fam = FAMILY_DS18S20;
      1:       fam = FAMILY_DS18B20;
      2:       fam = FAMILY_DS1822;
      default: fam = 8'($urandom);
    endcase
    lsb = 8'($urandom);
    msb = 8'($urandom);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       {msb, lsb} = 16'h0000;
        1:       {msb, lsb} = 16'hFFFF;
        2:       {msb, lsb} = 16'h7FFF;
        default: {msb, lsb} = 16'h8000;
      endcase
    end
    per  = $urandom_range(1) ? COUNT_PER_C_NOMINAL : 8'($urandom);
    flip = (kind >= 70 && kind < 80) ? 8'($urandom_range(255, 1)) : 8'h00;
    if (kind < 80) begin
      send_frame(lsb, msb, 8'($urandom), 8'($urandom), per, fam, $urandom_range(99) < 85, flip);
    end else if (kind < 90) begin
      // truncated scratchpad
      n = $urandom_range(FRAME_LEN - 1, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), 8'($urandom), i == 0);
    end else begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        send_byte(8'($urandom), 8'($urandom), $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // ds18s20: shift overflows, with the count-remain refinement at nominal count-per-c
    send_frame(8'hFF, 8'h7F, 8'h00, 8'hFF, COUNT_PER_C_NOMINAL, FAMILY_DS18S20, 1'b1, 8'h00);
    // next byte is byte 0 without frame_start; unknown family with a good crc
    send_frame(8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h55, 1'b0, 8'h00);
    // partial scratchpad, then a restart mid-frame
    send_byte(8'hFF, 8'hFF, 1'b1);
    send_byte(8'h00, 8'h00, 1'b0);
    send_byte(8'hFF, 8'hFF, 1'b0);
    // crc mismatch on a known family, full resolution bits set
    send_frame(8'hFF, 8'hFF, 8'h7F, 8'h00, 8'hFF, FAMILY_DS18B20, 1'b1, 8'hFF);
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n_bytes);
    int first;
    idle_pct  = idle;
    stall_pct = stall;
    first     = bytes_sent;
    while (bytes_sent - first < n_bytes) send_random_scratchpad();
  endtask

  // receiver holds off while full scratchpads keep coming, so the block stalls its input
  task automatic test_backpressure();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_off_req = HOLD_OFF;
    repeat (4) begin
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), COUNT_PER_C_NOMINAL,
                 ($urandom_range(1) ? FAMILY_DS18S20 : FAMILY_DS1822), 1'b1, 8'h00);
    end
  endtask

  // result side stalling, with a counted hold-off on request
  initial begin
    int hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // checks every result transaction against the oldest expected reading
  initial begin
    reading_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("reading with none expected", int'(out_data.temperature), 0);
        end else begin
          want = pending_readings.pop_front();
          readings_checked++;
          status_seen[int'(want.status)]++;
          if (out_data.temperature !== want.temperature) begin
            report_mismatch("temperature", int'(out_data.temperature),
                            int'($signed(want.temperature)));
          end
          if (out_data.status !== want.status) begin
            report_mismatch("status", int'(out_data.status), int'(want.status));
          end
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("run did not complete in time");
    $display("simulation failed");
    $finish;
  end

  initial begin
    int waited;
    in_valid         = 1'b0;
    in_data          = '0;
    rst_n            = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_off_req     = 0;
    bytes_sent       = 0;
    readings_checked = 0;
    held_off_cycles  = 0;
    error_count      = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    pred_crc    = '0;
    pred_pos    = '0;
    held_lsb    = '0;
    held_msb    = '0;
    held_cfg    = '0;
    held_remain = '0;
    held_per    = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(0, 0, 300);
    test_random_phase(52, 0, 300);
    test_random_phase(0, 52, 300);
    test_random_phase(23, 23, 300);
    test_backpressure();

    in_valid  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    waited    = 0;
    while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_readings.size() != 0) begin
      $display("%0d readings never arrived", pending_readings.size());
      $display("simulation failed");
      $finish;
    end else begin
      repeat (10) @(negedge clk);
      $display("sent %0d scratchpad bytes, checked %0d readings: %0d ok, %0d crc error, %0d %s",
               bytes_sent, readings_checked, status_seen[int'(ST_OK)],
               status_seen[int'(ST_CRC_ERROR)], status_seen[int'(ST_UNKNOWN_FAMILY)],
               "unknown family");
      $display("input held off by the decoder for %0d cycles, %0d mismatches", held_off_cycles,
               error_count);
      if (error_count == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
      $finish;
    end
  end

endmodule
